FILE: sv/rist_pkg.sv
package rist_pkg;

	// fixed field widths at the ports
	localparam int MODE_W     = 2;
	localparam int DEV_W      = 16;
	localparam int OBJ_PORT_W = 32;
	localparam int IDX_PORT_W = 5;

	// request codes
	typedef enum logic [MODE_W-1:0] {
		MODE_GET = 2'd0,
		MODE_DUP = 2'd1,
		MODE_PUT = 2'd2
	} mode_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FETCH,
		ST_DECIDE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic cnt_clr;
		logic cnt_inc;
		logic clr_wr;
		logic scan_rd;
		logic fetch_rd;
		logic decide;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_get;
		logic req_bad;
		logic cnt_last;
	} dp_sts_t;

endpackage

FILE: sv/refcounted_inode_slot_table.sv
// Reference-counted slot table: TABLE_SLOTS slots of (device, object, use count).
// Input channel in_valid/in_stall carries one request item (mode, device,
// object_number, slot_index); the block drives in_stall. Output channel
// out_valid/out_stall carries one result item per request; the receiver
// drives out_stall. Config channel cfg_valid/cfg_ready/cfg_data writes the
// no-device code; cfg_ready is always high, write it only while idle.
// A get passes the scan, tail and decide states, dup/put the fetch and decide
// states; refused requests go straight to decide, and out_valid is registered
// from the decide step. A get reads every slot through the single read port of
// the slot memory, one slot per cycle. One item is worked on at a time.
// After reset a clearing pass zeroes all use counts with in_stall high; the
// no-device code resets to 0.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile and holds in its decide step until the
// output register is free.
module refcounted_inode_slot_table import rist_pkg::*; #(
	parameter int TABLE_SLOTS = 32,
	parameter int OBJECT_BITS = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DEV_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DEV_W-1:0]      device,
	input  logic [OBJ_PORT_W-1:0] object_number,
	input  logic [IDX_PORT_W-1:0] slot_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_PORT_W-1:0] slot_out,
	output logic                  hit,
	output logic                  load_needed,
	output logic                  table_full,
	output logic                  released,
	output logic                  bad_request
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// controller
	rist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	rist_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.OBJECT_BITS (OBJECT_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.device        (device),
		.object_number (object_number),
		.slot_index    (slot_index),
		.slot_out      (slot_out),
		.hit           (hit),
		.load_needed   (load_needed),
		.table_full    (table_full),
		.released      (released),
		.bad_request   (bad_request)
	);

	// a result is never overwritten while it waits
	a_decide_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (!out_valid || !out_stall))
		else $error("result register loaded while occupied");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item accepted while busy");

	// full excludes every other flag
	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(table_full && (hit || load_needed || released || bad_request)))
		else $error("table_full with other flags");

	// memory writes never collide with a scan
	a_scan_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !(cmd.clr_wr || cmd.decide))
		else $error("write during scan");

endmodule

FILE: sv/rist_ctrl.sv
module rist_ctrl import rist_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.cnt_clr   = 1'b1;
					if (sts.req_bad)      state_d = ST_DECIDE;
					else if (sts.req_get) state_d = ST_SCAN;
					else                  state_d = ST_FETCH;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				state_d = ST_DECIDE;
			end
			ST_FETCH: begin
				cmd.fetch_rd = 1'b1;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result valid: set on decide, cleared when taken
	always_comb begin
		if (cmd.decide)     out_valid_d = 1'b1;
		else if (out_stall) out_valid_d = out_valid_q;
		else                out_valid_d = 1'b0;
	end

endmodule

FILE: sv/rist_dp.sv
module rist_dp import rist_pkg::*; #(
	parameter int TABLE_SLOTS = 32,
	parameter int OBJECT_BITS = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_we,
	input  logic [DEV_W-1:0]      cfg_data,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DEV_W-1:0]      device,
	input  logic [OBJ_PORT_W-1:0] object_number,
	input  logic [IDX_PORT_W-1:0] slot_index,
	output logic [IDX_PORT_W-1:0] slot_out,
	output logic                  hit,
	output logic                  load_needed,
	output logic                  table_full,
	output logic                  released,
	output logic                  bad_request
);

	localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CMP_W   = ((SLOT_W > IDX_PORT_W) ? SLOT_W : IDX_PORT_W) + 1;
	localparam int OBJ_LSB = 0;
	localparam int DEV_LSB = OBJECT_BITS;
	localparam int USE_LSB = OBJECT_BITS + DEV_W;
	localparam int ENTRY_W = OBJECT_BITS + DEV_W + COUNT_BITS;

	// slot memory: {uses, device, object}
	logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
	logic [ENTRY_W-1:0] rdata_s1;
	logic [SLOT_W-1:0]  eidx_s1;
	logic               scan_eval_s1;
	logic               rd_en, wr_en;
	logic [SLOT_W-1:0]  rd_addr, wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic [DEV_W-1:0]       no_dev_q;
	logic [SLOT_W-1:0]      cnt_q;
	mode_t                  mode_q;
	logic                   bad_q;
	logic [DEV_W-1:0]       dev_q;
	logic [OBJECT_BITS-1:0] obj_q;
	logic [IDX_PORT_W-1:0]  idx_q;

	logic                  found_q, have_free_q;
	logic [SLOT_W-1:0]     match_q, free_q;
	logic [COUNT_BITS-1:0] match_uses_q;

	logic                  idx_ok;
	logic [COUNT_BITS-1:0] e_uses, rd_uses;
	logic [DEV_W-1:0]      e_dev;
	logic [OBJECT_BITS-1:0] e_obj;

	logic [IDX_PORT_W-1:0] r_slot;
	logic                  r_hit, r_load, r_full, r_rel, r_bad;
	logic                  d_wr;
	logic [SLOT_W-1:0]     d_addr;
	logic [COUNT_BITS-1:0] d_uses;
	logic [DEV_W-1:0]      d_dev;
	logic [OBJECT_BITS-1:0] d_obj;

	// request classification from the live input item
	assign idx_ok       = (CMP_W'(slot_index) < CMP_W'(TABLE_SLOTS));
	assign sts.req_get  = (mode == MODE_GET);
	assign sts.req_bad  = !((mode == MODE_DUP || mode == MODE_PUT) && idx_ok)
	                      && (mode != MODE_GET);
	assign sts.cnt_last = (cnt_q == SLOT_W'(TABLE_SLOTS - 1));

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     no_dev_q <= '0;
		else if (cfg_we) no_dev_q <= cfg_data;
	end

	// slot counter for clearing and scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          cnt_q <= '0;
		else if (cmd.cnt_clr) cnt_q <= '0;
		else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode_t'(mode);
			bad_q  <= sts.req_bad;
			dev_q  <= device;
			obj_q  <= OBJECT_BITS'(object_number);
			idx_q  <= slot_index;
		end
	end

	// memory ports
	assign rd_en   = cmd.scan_rd || cmd.fetch_rd;
	assign rd_addr = cmd.scan_rd ? cnt_q : SLOT_W'(idx_q);
	assign wr_en   = cmd.clr_wr || (cmd.decide && d_wr);
	assign wr_addr = cmd.clr_wr ? cnt_q : d_addr;
	assign wr_data = cmd.clr_wr ? '0 : {d_uses, d_dev, d_obj};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			eidx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_eval_s1 <= 1'b0;
		else         scan_eval_s1 <= cmd.scan_rd;
	end

	assign e_uses  = rdata_s1[USE_LSB +: COUNT_BITS];
	assign e_dev   = rdata_s1[DEV_LSB +: DEV_W];
	assign e_obj   = rdata_s1[OBJ_LSB +: OBJECT_BITS];
	assign rd_uses = e_uses;

	// scan accumulation: first used match, last free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end else if (cmd.load_item) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end else if (scan_eval_s1) begin
			if (e_uses != '0) begin
				if (!found_q && e_dev == dev_q && e_obj == obj_q) found_q <= 1'b1;
			end else begin
				have_free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_eval_s1) begin
			if (e_uses != '0) begin
				if (!found_q && e_dev == dev_q && e_obj == obj_q) begin
					match_q      <= eidx_s1;
					match_uses_q <= e_uses;
				end
			end else begin
				free_q <= eidx_s1;
			end
		end
	end

	// result and update decision
	always_comb begin
		r_slot = '0;
		r_hit  = 1'b0;
		r_load = 1'b0;
		r_full = 1'b0;
		r_rel  = 1'b0;
		r_bad  = 1'b0;
		d_wr   = 1'b0;
		d_addr = SLOT_W'(idx_q);
		d_uses = rd_uses;
		d_dev  = e_dev;
		d_obj  = e_obj;
		if (bad_q) begin
			r_bad = 1'b1;
			if (mode_q == MODE_DUP || mode_q == MODE_PUT) r_slot = idx_q;
		end else begin
			case (mode_q)
				MODE_GET: begin
					d_dev = dev_q;
					d_obj = obj_q;
					if (found_q) begin
						r_hit  = 1'b1;
						r_slot = IDX_PORT_W'(match_q);
						d_addr = match_q;
						if (match_uses_q == '1) begin
							r_bad = 1'b1;
						end else begin
							d_wr   = 1'b1;
							d_uses = match_uses_q + 1'b1;
						end
					end else if (!have_free_q) begin
						r_full = 1'b1;
					end else begin
						r_slot = IDX_PORT_W'(free_q);
						d_addr = free_q;
						d_wr   = 1'b1;
						d_uses = COUNT_BITS'(1);
						r_load = (dev_q != no_dev_q);
					end
				end
				MODE_DUP: begin
					r_slot = idx_q;
					if (rd_uses == '1) begin
						r_bad = 1'b1;
					end else begin
						d_wr   = 1'b1;
						d_uses = rd_uses + 1'b1;
					end
				end
				MODE_PUT: begin
					r_slot = idx_q;
					if (rd_uses == '0) begin
						r_bad = 1'b1;
					end else begin
						d_wr   = 1'b1;
						d_uses = rd_uses - 1'b1;
						r_rel  = (rd_uses == COUNT_BITS'(1));
					end
				end
				default: begin
					r_bad = 1'b1;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			slot_out    <= r_slot;
			hit         <= r_hit;
			load_needed <= r_load;
			table_full  <= r_full;
			released    <= r_rel;
			bad_request <= r_bad;
		end
	end

endmodule
